// ----- src/fssg_pkg.sv -----
`default_nettype none

package fssg_pkg;

    // Fan and tachometer constants.
    localparam int TACH_PPR        = 42;
    localparam int DUTY_FULL_SCALE = 8191;
    localparam int RECOVERY_PCT    = 30;
    localparam int RPM_SCALE       = 60000;
    localparam int PCT_FULL        = 100;
    localparam int RETRY_MAX       = 15;

    // Field and register widths.
    localparam int REQ_W     = 2;
    localparam int PULSE_W   = 8;
    localparam int PREQ_W    = 8;
    localparam int DUTY_W    = 13;
    localparam int RPM_W     = 16;
    localparam int RETRY_W   = 4;
    localparam int PCT_W     = 7;
    localparam int WIN_W     = 10;
    localparam int REC_W     = 14;
    localparam int RPP_W     = 10;
    localparam int ACC_W     = 18;
    localparam int PPR_W     = 8;
    localparam int DEN_W     = WIN_W + PPR_W;
    localparam int NUM_W     = DEN_W + RPM_W;
    localparam int EXP_W     = PCT_W + RPP_W;
    localparam int CMP_W     = 24;
    localparam int DIV_CNT_W = 4;

    localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

    // Stream word widths.
    localparam int S_DATA_W = PULSE_W + PREQ_W;
    localparam int M_FIELDS_W = DUTY_W + RPM_W + 1 + RETRY_W + 1 + 1 + 1;
    localparam int M_DATA_W = ((M_FIELDS_W + 7) / 8) * 8;

    // Configuration port.
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 14;

    localparam logic [CFG_ADDR_W-1:0] CFG_CHECK_WINDOW = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_RECOVERY     = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_RETRY_LIMIT  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_DROP_PCT     = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_RPM_PER_PCT  = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_MIN_POWER    = 3'd5;

    // Request kinds.
    localparam logic [REQ_W-1:0] REQ_TICK  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_POWER = 2'd1;
    localparam logic [REQ_W-1:0] REQ_STOP  = 2'd2;

    typedef struct packed {
        logic [WIN_W-1:0]   check_window_ms;
        logic [REC_W-1:0]   recovery_ms;
        logic [RETRY_W-1:0] retry_limit;
        logic [PCT_W-1:0]   drop_percent;
        logic [RPP_W-1:0]   rpm_per_percent;
        logic [PCT_W-1:0]   min_check_power;
    } cfg_t;

    typedef struct packed {
        logic decode;
        logic mul;
        logic prep;
        logic div_step;
        logic chk_a;
        logic chk_b;
        logic chk_c;
        logic restart;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic win_end;
        logic sat;
        logic div_last;
        logic chk_en;
        logic out_free;
    } dp_sts_t;

    typedef logic [(1 << PCT_W)-1:0][DUTY_W-1:0] duty_tab_t;

    function automatic duty_tab_t build_duty_tab();
        duty_tab_t t;
        for (int i = 0; i < (1 << PCT_W); i++) begin
            t[i] = DUTY_W'((i * DUTY_FULL_SCALE) / PCT_FULL);
        end
        return t;
    endfunction

    localparam duty_tab_t DUTY_TAB = build_duty_tab();

endpackage

`default_nettype wire

// ----- src/fssg_cfg.sv -----
`default_nettype none

module fssg_cfg (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              cfg_we,
    input  wire  [fssg_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  wire  [fssg_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output fssg_pkg::cfg_t                   cfg
);
    import fssg_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.check_window_ms <= WIN_W'(100);
            cfg_reg.recovery_ms     <= REC_W'(1000);
            cfg_reg.retry_limit     <= RETRY_W'(3);
            cfg_reg.drop_percent    <= PCT_W'(30);
            cfg_reg.rpm_per_percent <= RPP_W'(250);
            cfg_reg.min_check_power <= PCT_W'(30);
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_CHECK_WINDOW: cfg_reg.check_window_ms <= cfg_wdata[WIN_W-1:0];
                CFG_RECOVERY:     cfg_reg.recovery_ms     <= cfg_wdata[REC_W-1:0];
                CFG_RETRY_LIMIT:  cfg_reg.retry_limit     <= cfg_wdata[RETRY_W-1:0];
                CFG_DROP_PCT:     cfg_reg.drop_percent    <= cfg_wdata[PCT_W-1:0];
                CFG_RPM_PER_PCT:  cfg_reg.rpm_per_percent <= cfg_wdata[RPP_W-1:0];
                CFG_MIN_POWER:    cfg_reg.min_check_power <= cfg_wdata[PCT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ----- src/fssg_ctrl.sv -----
`default_nettype none

module fssg_ctrl (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                s_accept,
    input  fssg_pkg::dp_sts_t  sts,
    output logic               s_tready,
    output fssg_pkg::dp_cmd_t  cmd
);
    import fssg_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_MUL,
        ST_PREP,
        ST_DIV,
        ST_CHK_A,
        ST_CHK_B,
        ST_CHK_C,
        ST_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) state_next = ST_DECODE;
            end
            ST_DECODE: begin
                cmd.decode = 1'b1;
                state_next = sts.win_end ? ST_MUL : ST_OUT;
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_PREP;
            end
            ST_PREP: begin
                cmd.prep   = 1'b1;
                state_next = sts.sat ? ST_CHK_A : ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) state_next = ST_CHK_A;
            end
            ST_CHK_A: begin
                // A skipped check still restarts the window.
                cmd.chk_a = 1'b1;
                if (sts.chk_en) begin
                    state_next = ST_CHK_B;
                end else begin
                    cmd.restart = 1'b1;
                    state_next  = ST_OUT;
                end
            end
            ST_CHK_B: begin
                cmd.chk_b  = 1'b1;
                state_next = ST_CHK_C;
            end
            ST_CHK_C: begin
                cmd.chk_c   = 1'b1;
                cmd.restart = 1'b1;
                state_next  = ST_OUT;
            end
            ST_OUT: begin
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

endmodule

`default_nettype wire

// ----- src/fssg_dp.sv -----
`default_nettype none

module fssg_dp (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              s_accept,
    input  wire  [fssg_pkg::S_DATA_W-1:0]    s_tdata,
    input  wire  [fssg_pkg::REQ_W-1:0]       s_tuser,
    input  fssg_pkg::cfg_t                   cfg,
    input  fssg_pkg::dp_cmd_t                cmd,
    output fssg_pkg::dp_sts_t                sts,
    output logic                             m_tvalid,
    input  wire                              m_tready,
    output logic [fssg_pkg::M_DATA_W-1:0]    m_tdata
);
    import fssg_pkg::*;

    // Latched input word.
    logic [REQ_W-1:0]   req_reg;
    logic [PULSE_W-1:0] pulses_reg;
    logic [PREQ_W-1:0]  preq_reg;

    // Fan state.
    logic [PCT_W-1:0]   power_reg;
    logic [RETRY_W-1:0] retries_reg;
    logic               stalled_reg;
    logic               recovering_reg;
    logic [WIN_W-1:0]   window_ticks_reg;
    logic [ACC_W-1:0]   acc_reg;
    logic [REC_W-1:0]   rec_ticks_reg;
    logic [RPM_W-1:0]   rpm_reg;

    // Arithmetic work registers.
    logic [NUM_W-1:0]     num_reg;
    logic [DEN_W-1:0]     den_reg;
    logic [DEN_W-1:0]     rem_reg;
    logic [RPM_W-1:0]     low_reg;
    logic [RPM_W-1:0]     quo_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [EXP_W-1:0]     exp_reg;
    logic [CMP_W-1:0]     rpm1_reg;
    logic [CMP_W-1:0]     thr_reg;
    logic                 done_reg;
    logic                 seen_reg;

    logic [M_DATA_W-1:0] m_tdata_reg;
    logic                m_tvalid_reg;

    logic [ACC_W:0]     acc_sum;
    logic [ACC_W-1:0]   acc_next;
    logic [WIN_W-1:0]   window_ticks_next;
    logic [WIN_W-1:0]   win_lim;
    logic [REC_W-1:0]   rec_ticks_next;
    logic [REC_W-1:0]   rec_lim;
    logic [PCT_W-1:0]   preq_clamped;
    logic [PCT_W-1:0]   drop_eff;
    logic [PCT_W-1:0]   keep_pct;
    logic [DEN_W:0]     div_shift;
    logic               div_ge;
    logic [DEN_W:0]     div_diff;
    logic [RETRY_W-1:0] retries_next;
    logic               stall_found;
    logic [DUTY_W-1:0]  duty_now;

    assign acc_sum  = {1'b0, acc_reg} + (ACC_W + 1)'(pulses_reg);
    assign acc_next = (acc_sum > {1'b0, ACC_MAX}) ? ACC_MAX : acc_sum[ACC_W-1:0];

    assign window_ticks_next = window_ticks_reg + WIN_W'(1);
    assign win_lim = (cfg.check_window_ms == '0) ? WIN_W'(1) : cfg.check_window_ms;
    assign rec_ticks_next = rec_ticks_reg + REC_W'(1);
    assign rec_lim = (cfg.recovery_ms == '0) ? REC_W'(1) : cfg.recovery_ms;

    assign preq_clamped = (preq_reg > PREQ_W'(PCT_FULL)) ? PCT_W'(PCT_FULL)
                                                         : preq_reg[PCT_W-1:0];
    assign drop_eff = (cfg.drop_percent > PCT_W'(PCT_FULL)) ? PCT_W'(PCT_FULL)
                                                            : cfg.drop_percent;
    assign keep_pct = PCT_W'(PCT_FULL) - drop_eff;

    // One quotient bit per step of the long division.
    assign div_shift = {rem_reg, low_reg[RPM_W-1]};
    assign div_ge    = div_shift >= {1'b0, den_reg};
    assign div_diff  = div_shift - {1'b0, den_reg};

    assign retries_next = (retries_reg < RETRY_W'(RETRY_MAX)) ? retries_reg + RETRY_W'(1)
                                                              : retries_reg;
    // rpm < floor(t / 100) holds exactly when (rpm + 1) * 100 <= t.
    assign stall_found = rpm1_reg <= thr_reg;

    always_comb begin
        priority if (stalled_reg) begin
            duty_now = '0;
        end else if (recovering_reg) begin
            duty_now = DUTY_TAB[RECOVERY_PCT];
        end else begin
            duty_now = DUTY_TAB[power_reg];
        end
    end

    assign sts.win_end  = (req_reg == REQ_TICK) && !recovering_reg
                          && (window_ticks_next >= win_lim);
    assign sts.sat      = num_reg >= {den_reg, {RPM_W{1'b0}}};
    assign sts.div_last = (div_cnt_reg == {DIV_CNT_W{1'b1}});
    assign sts.chk_en   = !stalled_reg && (power_reg >= cfg.min_check_power);
    assign sts.out_free = !m_tvalid_reg || m_tready;

    // Input word latch.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            req_reg    <= s_tuser;
            pulses_reg <= s_tdata[PULSE_W-1:0];
            preq_reg   <= s_tdata[S_DATA_W-1:PULSE_W];
        end
    end

    // Fan state, set on accept, decode, divide, check and restart.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            power_reg        <= '0;
            retries_reg      <= '0;
            stalled_reg      <= 1'b0;
            recovering_reg   <= 1'b0;
            window_ticks_reg <= '0;
            acc_reg          <= '0;
            rec_ticks_reg    <= '0;
            rpm_reg          <= '0;
            done_reg         <= 1'b0;
            seen_reg         <= 1'b0;
        end else begin
            if (s_accept) begin
                done_reg <= 1'b0;
                seen_reg <= 1'b0;
            end
            if (cmd.decode) begin
                unique case (req_reg)
                    REQ_TICK: begin
                        if (recovering_reg) begin
                            if (rec_ticks_next >= rec_lim) begin
                                recovering_reg   <= 1'b0;
                                rec_ticks_reg    <= '0;
                                window_ticks_reg <= '0;
                                acc_reg          <= '0;
                            end else begin
                                rec_ticks_reg <= rec_ticks_next;
                            end
                        end else begin
                            acc_reg          <= acc_next;
                            window_ticks_reg <= window_ticks_next;
                        end
                    end
                    REQ_POWER: begin
                        if (!stalled_reg) power_reg <= preq_clamped;
                    end
                    REQ_STOP: begin
                        power_reg      <= '0;
                        retries_reg    <= '0;
                        stalled_reg    <= 1'b0;
                        recovering_reg <= 1'b0;
                        rec_ticks_reg  <= '0;
                    end
                    default: begin
                    end
                endcase
            end
            if (cmd.prep && sts.sat) begin
                rpm_reg <= {RPM_W{1'b1}};
            end
            if (cmd.div_step && sts.div_last) begin
                rpm_reg <= {quo_reg[RPM_W-2:0], div_ge};
            end
            if (cmd.chk_c) begin
                done_reg <= 1'b1;
                if (stall_found) begin
                    seen_reg    <= 1'b1;
                    retries_reg <= retries_next;
                    if (retries_next >= cfg.retry_limit) begin
                        stalled_reg    <= 1'b1;
                        power_reg      <= '0;
                        recovering_reg <= 1'b0;
                        rec_ticks_reg  <= '0;
                    end else begin
                        recovering_reg <= 1'b1;
                        rec_ticks_reg  <= '0;
                    end
                end else begin
                    retries_reg <= '0;
                end
            end
            if (cmd.restart) begin
                window_ticks_reg <= '0;
                acc_reg          <= '0;
            end
        end
    end

    // RPM measurement and threshold arithmetic.
    always_ff @(posedge aclk) begin
        if (cmd.mul) begin
            num_reg <= NUM_W'(acc_reg) * NUM_W'(RPM_SCALE);
            den_reg <= DEN_W'(window_ticks_reg) * DEN_W'(TACH_PPR);
        end
        if (cmd.prep) begin
            rem_reg     <= num_reg[NUM_W-1:RPM_W];
            low_reg     <= num_reg[RPM_W-1:0];
            quo_reg     <= '0;
            div_cnt_reg <= '0;
        end
        if (cmd.div_step) begin
            rem_reg     <= div_ge ? div_diff[DEN_W-1:0] : div_shift[DEN_W-1:0];
            low_reg     <= {low_reg[RPM_W-2:0], 1'b0};
            quo_reg     <= {quo_reg[RPM_W-2:0], div_ge};
            div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
        end
        if (cmd.chk_a) begin
            exp_reg  <= EXP_W'(power_reg) * EXP_W'(cfg.rpm_per_percent);
            rpm1_reg <= (CMP_W'(rpm_reg) + CMP_W'(1)) * CMP_W'(PCT_FULL);
        end
        if (cmd.chk_b) begin
            thr_reg <= CMP_W'(exp_reg) * CMP_W'(keep_pct);
        end
    end

    // Output word register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_tdata_reg <= M_DATA_W'({seen_reg, done_reg, recovering_reg, retries_reg,
                                      stalled_reg, rpm_reg, duty_now});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

// ----- src/fan_speed_stall_guard_core.sv -----
// Fan power control with tachometer stall detection and retry.
// Input words arrive on the s_ channel: s_tuser carries the request kind (tick, set
// power, stop) and s_tdata the tachometer pulses of a one-millisecond tick and the
// requested power. Every input word yields exactly one status word on the m_ channel:
// PWM duty, last measured RPM, stall latch, retry count, recovery flag and the outcome
// of a stall check evaluated on that word.
// Power and stop words, and ticks that do not close a check window, pass from the
// decode state straight to the output state. A tick that closes the window also runs
// the RPM measurement: a multiply, a 16-step restoring divider (one quotient bit per
// cycle) and a threshold check (CHK_A, CHK_B, CHK_C); a skipped check stops after
// CHK_A, and a saturated RPM skips the 16 divider steps. The block takes
// one word at a time, so the next word is accepted once the previous status word has
// been loaded into the output register.
// When the receiver stalls, the finished word waits in the output register and the
// next input word is still accepted and processed; it then waits until the output
// register frees up.
// Reset (aresetn low, synchronous) loads the configuration defaults and clears all
// fan state. Configuration registers are written through cfg_we/cfg_addr/cfg_wdata
// and should only be changed while the block is idle.
`default_nettype none

module fan_speed_stall_guard_core (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              s_tvalid,
    output logic                             s_tready,
    // tach_pulses[7:0], power_request[15:8]
    input  wire  [fssg_pkg::S_DATA_W-1:0]    s_tdata,
    // req_type[1:0]
    input  wire  [fssg_pkg::REQ_W-1:0]       s_tuser,
    output logic                             m_tvalid,
    input  wire                              m_tready,
    // duty_value[12:0], measured_rpm[28:13], stall_latched[29], retry_count[33:30],
    // in_recovery[34], check_done[35], stall_seen[36], zero fill[39:37]
    output logic [fssg_pkg::M_DATA_W-1:0]    m_tdata,
    input  wire                              cfg_we,
    input  wire  [fssg_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  wire  [fssg_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import fssg_pkg::*;

    cfg_t    cfg;
    dp_cmd_t cmd;
    dp_sts_t sts;
    logic    s_accept;

    assign s_accept = s_tvalid && s_tready;

    fssg_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    fssg_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_accept (s_accept),
        .sts      (sts),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    fssg_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_accept (s_accept),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cfg      (cfg),
        .cmd      (cmd),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
`default_nettype none

module testbench;
    import fssg_pkg::*;

    // Request code that the block does not define; it must leave the state alone.
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int N_PHASES = 8;
    localparam int PHASE_ITEMS = 60;
    localparam int HOLD_CYCLES = 400;

    // Status word as it sits in m_tdata, first member in the highest bits.
    typedef struct packed {
        logic               stall_seen;
        logic               check_done;
        logic               in_recovery;
        logic [RETRY_W-1:0] retry_count;
        logic               stall_latched;
        logic [RPM_W-1:0]   measured_rpm;
        logic [DUTY_W-1:0]  duty_value;
    } fan_status_t;

    typedef struct {
        bit                    is_cfg;
        logic [CFG_ADDR_W-1:0] addr;
        logic [CFG_DATA_W-1:0] value;
        logic [REQ_W-1:0]      req;
        logic [PULSE_W-1:0]    pulses;
        logic [PREQ_W-1:0]     preq;
        bit                    typed;
        fan_status_t           status;
    } step_row_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;
    logic [REQ_W-1:0]      s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    fan_speed_stall_guard_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // Predictor copy of the configuration and the fan state.
    logic [WIN_W-1:0]   reg_window;
    logic [REC_W-1:0]   reg_recovery;
    logic [RETRY_W-1:0] reg_retry_limit;
    logic [PCT_W-1:0]   reg_drop;
    logic [RPP_W-1:0]   reg_rpm_per_pct;
    logic [PCT_W-1:0]   reg_min_power;

    logic [PCT_W-1:0]   fan_power;
    logic [RETRY_W-1:0] fan_retries;
    logic               fan_stalled;
    logic               fan_recovering;
    logic [WIN_W-1:0]   win_ticks;
    logic [ACC_W-1:0]   pulse_sum;
    logic [REC_W-1:0]   rec_ticks;
    logic [RPM_W-1:0]   last_rpm;

    fan_status_t pending_status[$];
    step_row_t   plan[$];
    int          n_errors;
    bit          steady;
    bit          rx_hold_req;

    always #1 aclk = ~aclk;

    function automatic fan_status_t fan_status(int unsigned duty, int unsigned rpm, bit latched,
                                               int unsigned retries, bit recov, bit done,
                                               bit seen);
        fan_status_t st;
        st.duty_value    = DUTY_W'(duty);
        st.measured_rpm  = RPM_W'(rpm);
        st.stall_latched = latched;
        st.retry_count   = RETRY_W'(retries);
        st.in_recovery   = recov;
        st.check_done    = done;
        st.stall_seen    = seen;
        return st;
    endfunction

    function automatic step_row_t cfg_row(logic [CFG_ADDR_W-1:0] addr, int unsigned value);
        step_row_t r;
        r = '{default: '0};
        r.is_cfg = 1'b1;
        r.addr   = addr;
        r.value  = CFG_DATA_W'(value);
        return r;
    endfunction

    function automatic step_row_t item_row(logic [REQ_W-1:0] req, int unsigned pulses,
                                           int unsigned preq);
        step_row_t r;
        r = '{default: '0};
        r.req    = req;
        r.pulses = PULSE_W'(pulses);
        r.preq   = PREQ_W'(preq);
        return r;
    endfunction

    function automatic step_row_t typed_row(logic [REQ_W-1:0] req, int unsigned pulses,
                                            int unsigned preq, fan_status_t st);
        step_row_t r;
        r        = item_row(req, pulses, preq);
        r.typed  = 1'b1;
        r.status = st;
        return r;
    endfunction

    task automatic predict_fan_status(input logic [REQ_W-1:0] req,
                                      input logic [PULSE_W-1:0] pulses,
                                      input logic [PREQ_W-1:0] preq,
                                      output fan_status_t st);
        int unsigned       win, rec, drop, sum, pct;
        longint unsigned   num, den, rpm_full, thresh;
        st = '0;
        case (req)
            REQ_TICK: begin
                if (fan_recovering) begin
                    // Recovery ticks only count down the recovery time.
                    rec = (reg_recovery == 0) ? 1 : reg_recovery;
                    rec_ticks = rec_ticks + 1'b1;
                    if (rec_ticks >= rec) begin
                        fan_recovering = 1'b0;
                        rec_ticks = '0;
                        win_ticks = '0;
                        pulse_sum = '0;
                    end
                end else begin
                    sum = pulse_sum + pulses;
                    if (sum > ACC_MAX) sum = ACC_MAX;
                    pulse_sum = ACC_W'(sum);
                    win_ticks = win_ticks + 1'b1;
                    win = (reg_window == 0) ? 1 : reg_window;
                    if (win_ticks >= win) begin
                        num = longint'(pulse_sum) * RPM_SCALE;
                        den = longint'(win_ticks) * TACH_PPR;
                        rpm_full = num / den;
                        last_rpm = (rpm_full > 65535) ? 16'hFFFF : RPM_W'(rpm_full);
                        if (!fan_stalled && fan_power >= reg_min_power) begin
                            st.check_done = 1'b1;
                            drop = (reg_drop > PCT_FULL) ? PCT_FULL : reg_drop;
                            thresh = longint'(fan_power) * reg_rpm_per_pct;
                            thresh = thresh * (PCT_FULL - drop) / PCT_FULL;
                            if (last_rpm < thresh) begin
                                st.stall_seen = 1'b1;
                                if (fan_retries < RETRY_MAX) fan_retries = fan_retries + 1'b1;
                                if (fan_retries >= reg_retry_limit) begin
                                    fan_stalled = 1'b1;
                                    fan_power = '0;
                                    fan_recovering = 1'b0;
                                end else begin
                                    fan_recovering = 1'b1;
                                end
                                rec_ticks = '0;
                            end else begin
                                fan_retries = '0;
                            end
                        end
                        win_ticks = '0;
                        pulse_sum = '0;
                    end
                end
            end
            REQ_POWER: begin
                if (!fan_stalled) begin
                    fan_power = (preq > PCT_FULL) ? PCT_W'(PCT_FULL) : preq[PCT_W-1:0];
                end
            end
            REQ_STOP: begin
                fan_power = '0;
                fan_retries = '0;
                fan_stalled = 1'b0;
                fan_recovering = 1'b0;
                rec_ticks = '0;
            end
            default: begin
            end
        endcase
        if (fan_stalled) pct = 0;
        else if (fan_recovering) pct = RECOVERY_PCT;
        else pct = fan_power;
        st.duty_value    = DUTY_W'((pct * DUTY_FULL_SCALE) / PCT_FULL);
        st.measured_rpm  = last_rpm;
        st.stall_latched = fan_stalled;
        st.retry_count   = fan_retries;
        st.in_recovery   = fan_recovering;
    endtask

    task automatic send_item(input logic [REQ_W-1:0] req, input logic [PULSE_W-1:0] pulses,
                             input logic [PREQ_W-1:0] preq, input bit typed,
                             input fan_status_t typed_status);
        fan_status_t pred;
        @(negedge aclk);
        while (!steady && $urandom_range(0, 99) < 6) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = req;
        s_tdata  = {preq, pulses};
        do @(posedge aclk); while (!s_tready);
        predict_fan_status(req, pulses, preq, pred);
        pending_status.push_back(typed ? typed_status : pred);
    endtask

    // Registers are only touched once every status word has come back.
    task automatic settle();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending_status.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input int unsigned value);
        @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_addr  = addr;
        cfg_wdata = CFG_DATA_W'(value);
        case (addr)
            CFG_CHECK_WINDOW: reg_window      = WIN_W'(value);
            CFG_RECOVERY:     reg_recovery    = REC_W'(value);
            CFG_RETRY_LIMIT:  reg_retry_limit = RETRY_W'(value);
            CFG_DROP_PCT:     reg_drop        = PCT_W'(value);
            CFG_RPM_PER_PCT:  reg_rpm_per_pct = RPP_W'(value);
            CFG_MIN_POWER:    reg_min_power   = PCT_W'(value);
            default: begin
            end
        endcase
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            n_errors++;
        end
    endtask

    always @(posedge aclk) begin
        fan_status_t want;
        fan_status_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[$bits(fan_status_t)-1:0];
            if (pending_status.size() == 0) begin
                $display("%0t: unexpected status word, expected none, actual %h",
                         $time, m_tdata);
                n_errors++;
            end else begin
                want = pending_status.pop_front();
                check_field("duty_value", want.duty_value, got.duty_value);
                check_field("measured_rpm", want.measured_rpm, got.measured_rpm);
                check_field("stall_latched", want.stall_latched, got.stall_latched);
                check_field("retry_count", want.retry_count, got.retry_count);
                check_field("in_recovery", want.in_recovery, got.in_recovery);
                check_field("check_done", want.check_done, got.check_done);
                check_field("stall_seen", want.stall_seen, got.stall_seen);
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off on request to back up the block.
    initial begin
        int hold_left;
        hold_left = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready = 1'b0;
            end else begin
                m_tready = steady || ($urandom_range(0, 99) >= 6);
            end
        end
    end

    initial begin
        #400000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        int unsigned  roll;
        int unsigned  cfg_vals[6];
        logic [REQ_W-1:0]   req;
        logic [PULSE_W-1:0] pulses;
        logic [PREQ_W-1:0]  preq;

        aclk = 1'b0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        n_errors = 0;
        steady = 1'b0;
        rx_hold_req = 1'b0;

        reg_window = 10'd100;
        reg_recovery = 14'd1000;
        reg_retry_limit = 4'd3;
        reg_drop = 7'd30;
        reg_rpm_per_pct = 10'd250;
        reg_min_power = 7'd30;
        fan_power = '0;
        fan_retries = '0;
        fan_stalled = 1'b0;
        fan_recovering = 1'b0;
        win_ticks = '0;
        pulse_sum = '0;
        rec_ticks = '0;
        last_rpm = '0;

        repeat (9) @(negedge aclk);
        aresetn = 1'b1;

        plan = '{
            typed_row(REQ_STOP, 0, 0, fan_status(0, 0, 0, 0, 0, 0, 0)),
            typed_row(REQ_POWER, 0, 255, fan_status(8191, 0, 0, 0, 0, 0, 0)),
            typed_row(REQ_UNUSED, 255, 255, fan_status(8191, 0, 0, 0, 0, 0, 0)),
            typed_row(REQ_TICK, 255, 0, fan_status(8191, 0, 0, 0, 0, 0, 0)),
            cfg_row(CFG_CHECK_WINDOW, 1),
            cfg_row(CFG_RECOVERY, 2),
            cfg_row(CFG_RETRY_LIMIT, 2),
            // Window closes with a saturated RPM and the check passes.
            item_row(REQ_TICK, 0, 0),
            // Empty window: first stall, recovery starts.
            item_row(REQ_TICK, 0, 0),
            item_row(REQ_POWER, 0, 50),
            item_row(REQ_TICK, 0, 0),
            item_row(REQ_TICK, 0, 0),
            // Second stall reaches the limit and latches.
            item_row(REQ_TICK, 0, 0),
            item_row(REQ_POWER, 0, 100),
            item_row(REQ_TICK, 255, 0),
            typed_row(REQ_STOP, 0, 0, fan_status(0, 65535, 0, 0, 0, 0, 0)),
            // A drop above 100 percent means no stall can be seen.
            cfg_row(CFG_DROP_PCT, 127),
            item_row(REQ_POWER, 0, 100),
            item_row(REQ_TICK, 0, 0),
            item_row(REQ_POWER, 0, 29),
            item_row(REQ_TICK, 0, 0),
            item_row(REQ_POWER, 0, 0),
            item_row(REQ_TICK, 128, 128)
        };

        foreach (plan[i]) begin
            if (plan[i].is_cfg) begin
                settle();
                write_reg(plan[i].addr, plan[i].value);
            end else begin
                send_item(plan[i].req, plan[i].pulses, plan[i].preq, plan[i].typed,
                          plan[i].status);
            end
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            settle();
            case (ph)
                0: cfg_vals = '{0, 0, 0, 0, 1, 0};
                1: cfg_vals = '{1023, 16383, 15, 127, 1023, 127};
                2: cfg_vals = '{1, 1, 15, 100, 655, 100};
                default: begin
                    cfg_vals[0] = $urandom_range(1, 6);
                    cfg_vals[1] = $urandom_range(1, 5);
                    cfg_vals[2] = $urandom_range(1, 4);
                    cfg_vals[3] = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                                                              : $urandom_range(10, 50);
                    cfg_vals[4] = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                                              : $urandom_range(100, 400);
                    cfg_vals[5] = $urandom_range(0, 60);
                end
            endcase
            write_reg(CFG_CHECK_WINDOW, cfg_vals[0]);
            write_reg(CFG_RECOVERY, cfg_vals[1]);
            write_reg(CFG_RETRY_LIMIT, cfg_vals[2]);
            write_reg(CFG_DROP_PCT, cfg_vals[3]);
            write_reg(CFG_RPM_PER_PCT, cfg_vals[4]);
            write_reg(CFG_MIN_POWER, cfg_vals[5]);
            steady = (ph == 5);
            if (ph == 4) rx_hold_req = 1'b1;

            for (int k = 0; k < PHASE_ITEMS; k++) begin
                roll = $urandom_range(0, 99);
                pulses = PULSE_W'($urandom);
                preq = PREQ_W'($urandom);
                // Mostly ticks with pulse counts near the stall threshold, some noise.
                if (roll < 70) begin
                    req = REQ_TICK;
                    if ($urandom_range(0, 4) != 0) pulses = PULSE_W'($urandom_range(0, 30));
                end else if (roll < 86) begin
                    req = REQ_POWER;
                    if ($urandom_range(0, 4) != 0) preq = PREQ_W'($urandom_range(30, 100));
                end else if (roll < 95) begin
                    req = REQ_STOP;
                end else begin
                    req = REQ_UNUSED;
                end
                send_item(req, pulses, preq, 1'b0, '0);
            end
        end

        steady = 1'b0;
        settle();
        repeat (30) @(posedge aclk);
        if (n_errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

`default_nettype wire
